>>> rtl/tmbl_pkg.sv
`default_nettype none

package tmbl_pkg;

    // Field widths
    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 16;
    localparam int COUNT_W     = 4;
    localparam int LEVEL_W     = 3;
    localparam int CFG_INDEX_W = 2;

    // Default for the number of ADC bits that are used
    localparam int SAMPLE_BITS_DEF = 12;

    // Samples per group
    localparam logic [COUNT_W-1:0] GROUP_LEN = COUNT_W'(10);

    // Group accumulator reset value for the smallest sample
    localparam logic [SAMPLE_W-1:0] SMALLEST_INIT = {SAMPLE_W{1'b1}};

    // Threshold reset values
    localparam logic [SAMPLE_W-1:0] LEVEL5_INIT = SAMPLE_W'(3600);
    localparam logic [SAMPLE_W-1:0] LEVEL4_INIT = SAMPLE_W'(3466);
    localparam logic [SAMPLE_W-1:0] LEVEL3_INIT = SAMPLE_W'(3333);
    localparam logic [SAMPLE_W-1:0] LEVEL2_INIT = SAMPLE_W'(3200);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL5 = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL4 = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL3 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL2 = CFG_INDEX_W'(3);

    // Battery level codes
    localparam logic [LEVEL_W-1:0] LEVEL_1 = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] LEVEL_2 = LEVEL_W'(2);
    localparam logic [LEVEL_W-1:0] LEVEL_3 = LEVEL_W'(3);
    localparam logic [LEVEL_W-1:0] LEVEL_4 = LEVEL_W'(4);
    localparam logic [LEVEL_W-1:0] LEVEL_5 = LEVEL_W'(5);

endpackage

`default_nettype wire

>>> rtl/trimmed_mean_battery_level_unit.sv
`default_nettype none

// Channel   Handshake               Payload
// --------  ----------------------  ------------------------------------------
// input     in_valid / in_ready     sample
// result    out_valid / out_ready   average, level, new_average, ready_res
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The accumulate, trim, shift and threshold compare all
// sit between the group state and the result register, so a new sample is
// taken every cycle while the result side keeps up.
// Reset (rst_n low) clears the group, the latched average and its flag, and
// loads the default thresholds. A stalled result holds in place; a new sample
// is taken in the cycle its result register frees up. Config is always ready.

module trimmed_mean_battery_level_unit #(
    parameter int SAMPLE_BITS = tmbl_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [tmbl_pkg::SAMPLE_W-1:0]        sample,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic      [tmbl_pkg::SAMPLE_W-1:0]        average,
    output logic      [tmbl_pkg::LEVEL_W-1:0]         level,
    output logic                                      new_average,
    output logic                                      ready_res,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tmbl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [tmbl_pkg::SAMPLE_W-1:0]        cfg_data
);

    import tmbl_pkg::*;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    // Thresholds
    logic [SAMPLE_W-1:0] level5_reg;
    logic [SAMPLE_W-1:0] level4_reg;
    logic [SAMPLE_W-1:0] level3_reg;
    logic [SAMPLE_W-1:0] level2_reg;

    // Group state
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] largest_reg;
    logic [SAMPLE_W-1:0] largest_next;
    logic [SAMPLE_W-1:0] smallest_reg;
    logic [SAMPLE_W-1:0] smallest_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [SAMPLE_W-1:0] latched_reg;
    logic [SAMPLE_W-1:0] latched_next;
    logic                valid_avg_reg;

    // Result register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] average_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  level_next;
    logic                fresh_reg;
    logic                ready_res_reg;

    logic [SAMPLE_W-1:0] sample_used;
    logic [SUM_W-1:0]    trimmed;
    logic                group_done;
    logic                in_take;

    // Accept a sample whenever the result register is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Accumulate, track extremes and trim on the last sample of a group
    always_comb
    begin
        sample_used   = sample & SAMPLE_MASK;
        sum_next      = sum_reg + SUM_W'(sample_used);
        largest_next  = (sample_used > largest_reg)  ? sample_used : largest_reg;
        smallest_next = (sample_used < smallest_reg) ? sample_used : smallest_reg;
        count_next    = count_reg + COUNT_W'(1);
        group_done    = (count_next >= GROUP_LEN);
        trimmed       = sum_next - SUM_W'(largest_next) - SUM_W'(smallest_next);
        latched_next  = group_done ? trimmed[SAMPLE_W+2:3] : latched_reg;
    end

    // Classify the latched average, highest level first
    always_comb
    begin
        priority if (latched_next >= level5_reg)
        begin
            level_next = LEVEL_5;
        end
        else if (latched_next >= level4_reg)
        begin
            level_next = LEVEL_4;
        end
        else if (latched_next >= level3_reg)
        begin
            level_next = LEVEL_3;
        end
        else if (latched_next >= level2_reg)
        begin
            level_next = LEVEL_2;
        end
        else
        begin
            level_next = LEVEL_1;
        end
    end

    // Write thresholds from the config channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level5_reg <= LEVEL5_INIT;
            level4_reg <= LEVEL4_INIT;
            level3_reg <= LEVEL3_INIT;
            level2_reg <= LEVEL2_INIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LEVEL5: level5_reg <= cfg_data;
                CFG_LEVEL4: level4_reg <= cfg_data;
                CFG_LEVEL3: level3_reg <= cfg_data;
                CFG_LEVEL2: level2_reg <= cfg_data;
                default:    level2_reg <= level2_reg;
            endcase
        end
    end

    // Advance the group state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            largest_reg   <= '0;
            smallest_reg  <= SMALLEST_INIT;
            count_reg     <= '0;
            latched_reg   <= '0;
            valid_avg_reg <= 1'b0;
        end
        else if (in_take)
        begin
            latched_reg <= latched_next;
            if (group_done)
            begin
                sum_reg       <= '0;
                largest_reg   <= '0;
                smallest_reg  <= SMALLEST_INIT;
                count_reg     <= '0;
                valid_avg_reg <= 1'b1;
            end
            else
            begin
                sum_reg      <= sum_next;
                largest_reg  <= largest_next;
                smallest_reg <= smallest_next;
                count_reg    <= count_next;
            end
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            average_reg   <= latched_next;
            level_reg     <= level_next;
            fresh_reg     <= group_done;
            ready_res_reg <= valid_avg_reg || group_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign average     = average_reg;
    assign level       = level_reg;
    assign new_average = fresh_reg;
    assign ready_res   = ready_res_reg;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tmbl_pkg::*;

    localparam int SAMPLE_BITS       = SAMPLE_BITS_DEF;
    localparam int SAMPLE_TOP        = (1 << SAMPLE_W) - 1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = {SAMPLE_W{1'b1}};
    localparam int PHASES            = 8;
    localparam int GROUPS_PER_PHASE  = 17;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int SETTLE_CYCLES     = 4;
    localparam int CYCLE_LIMIT       = 1000000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [LEVEL_W-1:0]  level;
        logic                new_average;
        logic                ready_res;
    } battery_report_t;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        bit                  pinned;
        battery_report_t     report;
    } stim_row_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    sample     = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [SAMPLE_W-1:0]    average;
    logic [LEVEL_W-1:0]     level;
    logic                   new_average;
    logic                   ready_res;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [SAMPLE_W-1:0]    cfg_data   = '0;

    // Sideband that travels with each input transaction
    bit              row_pinned = 1'b0;
    battery_report_t row_report = '0;

    // Idle control for the sender and the receiver
    bit in_calm        = 1'b0;
    bit out_calm       = 1'b0;
    bit long_stall_req = 1'b0;

    // Predictor state: group accumulators, latched average, thresholds
    logic [SUM_W-1:0]    grp_sum      = '0;
    logic [SAMPLE_W-1:0] grp_max      = '0;
    logic [SAMPLE_W-1:0] grp_min      = SMALLEST_INIT;
    logic [COUNT_W-1:0]  grp_count    = '0;
    logic [SAMPLE_W-1:0] held_average = '0;
    logic                held_valid   = 1'b0;
    logic [SAMPLE_W-1:0] thr [4]      = '{LEVEL5_INIT, LEVEL4_INIT, LEVEL3_INIT, LEVEL2_INIT};

    battery_report_t expected_reports [$];
    int              mismatch_count = 0;
    int unsigned     cycle_count    = 0;

    trimmed_mean_battery_level_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .average     (average),
        .level       (level),
        .new_average (new_average),
        .ready_res   (ready_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the group with one sample and return the report it produces
    function automatic battery_report_t absorb_sample(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] s;
        logic [SUM_W-1:0]    trimmed;
        battery_report_t     r;
        s = raw & SAMPLE_MASK;
        grp_sum = grp_sum + SUM_W'(s);
        if (s > grp_max)
            grp_max = s;
        if (s < grp_min)
            grp_min = s;
        grp_count = grp_count + COUNT_W'(1);
        r.new_average = 1'b0;
        if (grp_count >= GROUP_LEN)
        begin
            // Drop the largest and smallest, divide the other eight by 8
            trimmed      = grp_sum - SUM_W'(grp_max) - SUM_W'(grp_min);
            held_average = trimmed[SAMPLE_W+2:3];
            held_valid   = 1'b1;
            r.new_average = 1'b1;
            grp_sum   = '0;
            grp_max   = '0;
            grp_min   = SMALLEST_INIT;
            grp_count = '0;
        end
        r.average   = held_average;
        r.ready_res = held_valid;
        // First threshold met in priority order decides the level
        if (held_average >= thr[CFG_LEVEL5])
            r.level = LEVEL_5;
        else if (held_average >= thr[CFG_LEVEL4])
            r.level = LEVEL_4;
        else if (held_average >= thr[CFG_LEVEL3])
            r.level = LEVEL_3;
        else if (held_average >= thr[CFG_LEVEL2])
            r.level = LEVEL_2;
        else
            r.level = LEVEL_1;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic stim_row_t pinned_row(input logic [SAMPLE_W-1:0] s,
                                             input logic [SAMPLE_W-1:0] avg,
                                             input logic [LEVEL_W-1:0]  lvl,
                                             input logic                fresh,
                                             input logic                rdy);
        stim_row_t r;
        r.sample = s;
        r.pinned = 1'b1;
        r.report = '{average: avg, level: lvl, new_average: fresh, ready_res: rdy};
        return r;
    endfunction

    function automatic stim_row_t free_row(input logic [SAMPLE_W-1:0] s);
        stim_row_t r;
        r.sample = s;
        r.pinned = 1'b0;
        r.report = '0;
        return r;
    endfunction

    // Offer one sample after a random gap; return at the falling edge after acceptance
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit pinned,
                               input battery_report_t rep);
        int gap;
        gap = pick_gap(in_calm);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample     = s;
        row_pinned = pinned;
        row_report = rep;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_threshold(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [SAMPLE_W-1:0] value);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the input and wait until every expected report has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_reports.size() != 0 || out_valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Monitor: check result transactions, track config, predict input transactions
    always @(posedge clk)
    begin
        battery_report_t got;
        battery_report_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{average: average, level: level, new_average: new_average,
                        ready_res: ready_res};
                if (expected_reports.size() == 0)
                begin
                    $error("result transaction with nothing expected: average %0d level %0d",
                           got.average, got.level);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.average !== want.average)
                    begin
                        $error("average: expected %0d, got %0d", want.average, got.average);
                        mismatch_count++;
                    end
                    if (got.level !== want.level)
                    begin
                        $error("level: expected %0d, got %0d", want.level, got.level);
                        mismatch_count++;
                    end
                    if (got.new_average !== want.new_average)
                    begin
                        $error("new_average: expected %0d, got %0d",
                               want.new_average, got.new_average);
                        mismatch_count++;
                    end
                    if (got.ready_res !== want.ready_res)
                    begin
                        $error("ready_res: expected %0d, got %0d",
                               want.ready_res, got.ready_res);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                thr[cfg_index] = cfg_data;
            if (in_valid && in_ready)
            begin
                want = absorb_sample(sample);
                if (row_pinned)
                    want = row_report;
                expected_reports.push_back(want);
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        int idle;
        bit stall_served;
        stall_served = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall_req && !stall_served)
            begin
                out_ready = 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge clk);
                stall_served = 1'b1;
            end
            else
            begin
                idle = pick_gap(out_calm);
                out_ready = (idle == 0);
                if (idle > 1)
                    repeat (idle - 1) @(negedge clk);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t           directed_rows [$];
        int                  t5, t4, t3, t2;
        int                  mode, center, spread, v;
        logic [SAMPLE_W-1:0] s;

        // Directed table: a full-scale group, a zero group, then two threshold values and three other samples
        repeat (9) directed_rows.push_back(pinned_row(SAMPLE_MAX, '0, LEVEL_1, 1'b0, 1'b0));
        directed_rows.push_back(pinned_row(SAMPLE_MAX, SAMPLE_MAX, LEVEL_5, 1'b1, 1'b1));
        repeat (9) directed_rows.push_back(pinned_row('0, SAMPLE_MAX, LEVEL_5, 1'b0, 1'b1));
        directed_rows.push_back(pinned_row('0, '0, LEVEL_1, 1'b1, 1'b1));
        directed_rows.push_back(free_row(LEVEL5_INIT));
        directed_rows.push_back(free_row(LEVEL4_INIT));
        directed_rows.push_back(free_row(12'h555));
        directed_rows.push_back(free_row(12'hAAA));
        directed_rows.push_back(free_row(12'h001));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].sample, directed_rows[i].pinned,
                        directed_rows[i].report);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();

            // Pick this phase's thresholds
            case (ph)
                0:
                begin
                    t5 = LEVEL5_INIT; t4 = LEVEL4_INIT; t3 = LEVEL3_INIT; t2 = LEVEL2_INIT;
                end
                1:
                begin
                    t5 = SAMPLE_TOP; t4 = SAMPLE_TOP; t3 = SAMPLE_TOP; t2 = SAMPLE_TOP;
                end
                2:
                begin
                    t5 = 0; t4 = 0; t3 = 0; t2 = 0;
                end
                3:
                begin
                    // misordered thresholds
                    t5 = 1000; t4 = 3000; t3 = 2000; t2 = 500;
                end
                4:
                begin
                    // level one unreachable
                    t5 = 3000; t4 = 2000; t3 = 1000; t2 = 0;
                end
                7:
                begin
                    t5 = $urandom_range(0, SAMPLE_TOP);
                    t4 = $urandom_range(0, SAMPLE_TOP);
                    t3 = $urandom_range(0, SAMPLE_TOP);
                    t2 = $urandom_range(0, SAMPLE_TOP);
                end
                default:
                begin
                    t2 = $urandom_range(0, 1000);
                    t3 = t2 + $urandom_range(0, 1000);
                    t4 = t3 + $urandom_range(0, 1000);
                    t5 = t4 + $urandom_range(0, 1095);
                end
            endcase
            write_threshold(CFG_LEVEL5, SAMPLE_W'(t5));
            write_threshold(CFG_LEVEL4, SAMPLE_W'(t4));
            write_threshold(CFG_LEVEL3, SAMPLE_W'(t3));
            write_threshold(CFG_LEVEL2, SAMPLE_W'(t2));

            in_calm  = (ph == 3);
            out_calm = (ph == 3);

            // Realign to a group boundary
            if (grp_count != '0)
                repeat (int'(GROUP_LEN) - int'(grp_count))
                    send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)), 1'b0, '0);

            for (int g = 0; g < GROUPS_PER_PHASE; g++)
            begin
                if (ph == 2 && g == 5)
                    long_stall_req = 1'b1;
                if (ph == 5 && g == 8)
                    wait_drained();
                if (ph != 3)
                begin
                    in_calm  = ($urandom_range(0, 5) == 0);
                    out_calm = ($urandom_range(0, 5) == 0);
                end

                // Shape one group: noise, extremes, or a cluster near a threshold or a random point
                mode = $urandom_range(0, 9);
                if ($urandom_range(0, 1))
                    center = int'(thr[CFG_INDEX_W'($urandom_range(0, 3))])
                             + int'($urandom_range(0, 40)) - 20;
                else
                    center = $urandom_range(0, SAMPLE_TOP);
                spread = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(9, 200);
                for (int k = 0; k < GROUP_LEN; k++)
                begin
                    if (mode == 0)
                        s = SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
                    else if (mode == 1 || $urandom_range(0, 7) == 0)
                        s = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
                    else
                    begin
                        v = center + int'($urandom_range(0, 2 * spread)) - spread;
                        if (v < 0)
                            v = 0;
                        if (v > SAMPLE_TOP)
                            v = SAMPLE_TOP;
                        s = SAMPLE_W'(v);
                    end
                    send_sample(s, 1'b0, '0);
                end
                // Occasionally drop in a stray sample to break the group boundary
                if ($urandom_range(0, 9) == 0)
                    send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_TOP)), 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/tmbl_pkg.sv
rtl/trimmed_mean_battery_level_unit.sv
tb/sv/testbench.sv
